// ===== hdl/etm_pkg.sv =====
// ----------------------------------------------------------------------------
// etm_pkg: shared types and constants of the TRS model matrix block
// Angle constants, divide-by-quarter-turn reciprocal, pipeline depths and the
// quarter-wave sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package etm_pkg;

   localparam int FULL_TURN    = 23040;
   localparam int QUARTER_TURN = 5760;
   localparam int HALF_QUARTER = 2880;
   localparam int FRAC_W       = 13;

   localparam int RECIP_SHIFT = 40;
   localparam int RECIP_W     = 28;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / QUARTER_TURN;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam int LANE_STAGES  = 8;
   localparam int MERGE_STAGES = 5;
   localparam int NUM_STAGES   = LANE_STAGES + MERGE_STAGES;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] scale;
   } side_type;

   // Divides one Taylor term by (2k)(2k+1).
   function automatic longint unsigned taylor_div(input longint unsigned t, input int k);
      case (k)
         1: return t / 64'd6;
         2: return t / 64'd20;
         3: return t / 64'd42;
         4: return t / 64'd72;
         5: return t / 64'd110;
         6: return t / 64'd156;
         7: return t / 64'd210;
         8: return t / 64'd272;
         default: return t / 64'd342;
      endcase
   endfunction

   // Quarter-wave sine table entry for the angle x (radians in Q30), in Q(Frac).
   function automatic longint unsigned sine_entry(input longint unsigned x,
                                                  input int Frac);
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint e;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 9; k++) begin
         term = taylor_div((term * x2) >> 30, k);
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
      e = (sum + (64'sd1 <<< (29 - Frac))) >>> (30 - Frac);
      if (e > (64'sd1 <<< Frac)) e = 64'sd1 <<< Frac;
      return longint'(e);
   endfunction

endpackage

// ===== hdl/etm_sine_lane.sv =====
// ----------------------------------------------------------------------------
// etm_sine_lane: pipelined sine or cosine of one angle
// Reduces the angle to one turn, folds it into the first quadrant, and
// interpolates linearly between two entries of the quarter-wave table.
// ----------------------------------------------------------------------------
module etm_sine_lane #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int FRAC_BITS        = 16,
   parameter bit COSINE           = 1'b0
) (
   input  logic                                 clock,
   input  logic [etm_pkg::LANE_STAGES-1:0]      en,
   input  logic signed [15:0]                   angle,
   output logic signed [FRAC_BITS+1:0]          value
);
   import etm_pkg::*;

   localparam int D   = SINE_TABLE_DEPTH;
   localparam int F   = FRAC_BITS;
   localparam int SW  = F + 2;
   localparam int EW  = F + 1;
   localparam int PW  = $clog2(QUARTER_TURN * D + 1);
   localparam int IW  = $clog2(D + 1);
   localparam int AW  = $clog2(D);
   localparam int DFW = F - 4;
   localparam int NW  = DFW + FRAC_W;

   logic [EW-1:0] rom_lo [D];
   logic [EW-1:0] rom_hi [D];

   for (genvar g = 0; g < D; g++) begin : g_rom
      localparam longint unsigned X_LO = (HALF_PI_Q30 * g) / D;
      localparam longint unsigned X_HI = (HALF_PI_Q30 * (g + 1)) / D;
      assign rom_lo[g] = EW'(sine_entry(X_LO, F));
      assign rom_hi[g] = EW'(sine_entry(X_HI, F));
   end

   logic [6:0]         neg_ff;
   logic [FRAC_W-1:0]  rr_ff, rr_in;
   logic               neg_in;
   logic [PW-1:0]      pos_ff, pos3_ff;
   logic [IW-1:0]      est_ff, est_in, idx_ff, idx_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in, frac5_ff, frac5_in;
   logic [EW-1:0]      lo_ff, lo6_ff, lo7_ff, lo_in;
   logic [DFW-1:0]     diff_ff, diff_in, est2_ff, est2_in;
   logic [NW-1:0]      prod_ff, prod_in, prod7_ff;
   logic signed [SW-1:0] value_ff, value_in;

   logic [17:0]        ext;
   logic [16:0]        v;
   logic [14:0]        ar;
   logic [1:0]         qd;
   logic [FRAC_W-1:0]  r;
   logic [PW+RECIP_W-1:0] est_prod;
   logic [PW-1:0]      rem;
   logic [AW-1:0]      addr;
   logic [NW+RECIP_W-1:0] est2_prod;
   logic [NW-1:0]      rem2;
   logic [DFW-1:0]     quo;
   logic [EW-1:0]      mag;

   // Stage 1: reduce to [0, one turn), split into quadrant and offset.
   always_comb begin
      ext = {{2{angle[15]}}, angle} + 18'(2 * FULL_TURN);
      v = ext[16:0];
      if (v >= 17'(3 * FULL_TURN)) ar = 15'(v - 17'(3 * FULL_TURN));
      else if (v >= 17'(2 * FULL_TURN)) ar = 15'(v - 17'(2 * FULL_TURN));
      else if (v >= 17'(FULL_TURN)) ar = 15'(v - 17'(FULL_TURN));
      else ar = v[14:0];
      if (ar >= 15'(3 * QUARTER_TURN)) begin
         qd = 2'd3;
         r = FRAC_W'(ar - 15'(3 * QUARTER_TURN));
      end else if (ar >= 15'(2 * QUARTER_TURN)) begin
         qd = 2'd2;
         r = FRAC_W'(ar - 15'(2 * QUARTER_TURN));
      end else if (ar >= 15'(QUARTER_TURN)) begin
         qd = 2'd1;
         r = FRAC_W'(ar - 15'(QUARTER_TURN));
      end else begin
         qd = 2'd0;
         r = FRAC_W'(ar);
      end
      // A cosine is the sine one quadrant further on.
      if (COSINE) qd = qd + 2'd1;
      rr_in = qd[0] ? FRAC_W'(QUARTER_TURN) - r : r;
      neg_in = qd[1];
   end

   // Stages 3 and 4: table position divided by the quarter turn.
   always_comb begin
      est_prod = (PW+RECIP_W)'(pos_ff) * (PW+RECIP_W)'(RECIP);
      est_in = IW'(est_prod >> RECIP_SHIFT);
      rem = pos3_ff - PW'(PW'(est_ff) * PW'(QUARTER_TURN));
      if (rem >= PW'(QUARTER_TURN)) begin
         idx_in = est_ff + IW'(1);
         frac_in = FRAC_W'(rem - PW'(QUARTER_TURN));
      end else begin
         idx_in = est_ff;
         frac_in = FRAC_W'(rem);
      end
   end

   // Stage 5: table read. The quarter point interpolates fully to the end entry.
   always_comb begin
      if (idx_ff == IW'(D)) begin
         addr = AW'(D - 1);
         frac5_in = FRAC_W'(QUARTER_TURN);
      end else begin
         addr = idx_ff[AW-1:0];
         frac5_in = frac_ff;
      end
      lo_in = rom_lo[addr];
      diff_in = DFW'(rom_hi[addr] - rom_lo[addr]);
   end

   // Stages 6 to 8: rounded interpolation and sign.
   always_comb begin
      prod_in = NW'(diff_ff) * NW'(frac5_ff) + NW'(HALF_QUARTER);
      est2_prod = (NW+RECIP_W)'(prod_ff) * (NW+RECIP_W)'(RECIP);
      est2_in = DFW'(est2_prod >> RECIP_SHIFT);
      rem2 = prod7_ff - NW'(NW'(est2_ff) * NW'(QUARTER_TURN));
      quo = (rem2 >= NW'(QUARTER_TURN)) ? est2_ff + DFW'(1) : est2_ff;
      mag = lo7_ff + EW'(quo);
      value_in = neg_ff[6] ? -$signed(SW'(mag)) : $signed(SW'(mag));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rr_ff <= rr_in;
         neg_ff[0] <= neg_in;
      end
      if (en[1]) begin
         pos_ff <= PW'(rr_ff) * PW'(D);
         neg_ff[1] <= neg_ff[0];
      end
      if (en[2]) begin
         est_ff <= est_in;
         pos3_ff <= pos_ff;
         neg_ff[2] <= neg_ff[1];
      end
      if (en[3]) begin
         idx_ff <= idx_in;
         frac_ff <= frac_in;
         neg_ff[3] <= neg_ff[2];
      end
      if (en[4]) begin
         lo_ff <= lo_in;
         diff_ff <= diff_in;
         frac5_ff <= frac5_in;
         neg_ff[4] <= neg_ff[3];
      end
      if (en[5]) begin
         prod_ff <= prod_in;
         lo6_ff <= lo_ff;
         neg_ff[5] <= neg_ff[4];
      end
      if (en[6]) begin
         est2_ff <= est2_in;
         prod7_ff <= prod_ff;
         lo7_ff <= lo6_ff;
         neg_ff[6] <= neg_ff[5];
      end
      if (en[7]) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hdl/etm_merge.sv =====
// ----------------------------------------------------------------------------
// etm_merge: combines the six lane results into the scaled rotation
// Forms Ry*Rx*Rz from the sines and cosines, multiplies each column by its
// scale and saturates the nine entries to the 32-bit output range.
// ----------------------------------------------------------------------------
module etm_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic [etm_pkg::MERGE_STAGES-1:0]    en,
   input  logic signed [FRAC_BITS+1:0]         sin_x,
   input  logic signed [FRAC_BITS+1:0]         cos_x,
   input  logic signed [FRAC_BITS+1:0]         sin_y,
   input  logic signed [FRAC_BITS+1:0]         cos_y,
   input  logic signed [FRAC_BITS+1:0]         sin_z,
   input  logic signed [FRAC_BITS+1:0]         cos_z,
   input  logic [2:0][31:0]                    scale,
   output logic [8:0][31:0]                    m
);
   import etm_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int S  = F + 2;
   localparam int P  = 2 * S;
   localparam int PS = P + 1;
   localparam int RW = F + 3;
   localparam int MW = RW + 32;
   localparam int QW = MW - F;
   localparam longint HALF = 64'sd1 <<< (F - 1);
   localparam longint SAT_MAX = 64'sh7fffffff;
   localparam longint SAT_MIN = -64'sh80000000;

   logic signed [S-1:0] sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff, sx2_ff;
   logic signed [S-1:0] t_ff, u_ff, t_in, u_in;
   logic signed [P-1:0] p_ff [12];
   logic signed [P-1:0] p_in [12];
   logic signed [RW-1:0] rot_ff [9];
   logic signed [RW-1:0] rot_in [9];
   logic signed [MW-1:0] mp_ff [9];
   logic signed [MW-1:0] mp_in [9];
   logic [8:0][31:0] m_ff, m_in;

   logic signed [P-1:0] tp, up;
   logic signed [PS-1:0] sum [9];
   logic signed [QW-1:0] qv [9];

   always_comb begin
      tp = P'(sin_y) * P'(sin_x);
      up = P'(cos_y) * P'(sin_x);
      t_in = S'((tp + $signed(P'(HALF))) >>> F);
      u_in = S'((up + $signed(P'(HALF))) >>> F);
   end

   always_comb begin
      p_in[0]  = P'(cy_ff) * P'(cz_ff);
      p_in[1]  = P'(t_ff) * P'(sz_ff);
      p_in[2]  = P'(t_ff) * P'(cz_ff);
      p_in[3]  = P'(cy_ff) * P'(sz_ff);
      p_in[4]  = P'(sy_ff) * P'(cx_ff);
      p_in[5]  = P'(cx_ff) * P'(sz_ff);
      p_in[6]  = P'(cx_ff) * P'(cz_ff);
      p_in[7]  = P'(u_ff) * P'(sz_ff);
      p_in[8]  = P'(sy_ff) * P'(cz_ff);
      p_in[9]  = P'(sy_ff) * P'(sz_ff);
      p_in[10] = P'(u_ff) * P'(cz_ff);
      p_in[11] = P'(cy_ff) * P'(cx_ff);
   end

   always_comb begin
      sum[0] = PS'(p_ff[0]) + PS'(p_ff[1]);
      sum[1] = PS'(p_ff[2]) - PS'(p_ff[3]);
      sum[2] = PS'(p_ff[4]);
      sum[3] = PS'(p_ff[5]);
      sum[4] = PS'(p_ff[6]);
      sum[5] = '0;
      sum[6] = PS'(p_ff[7]) - PS'(p_ff[8]);
      sum[7] = PS'(p_ff[9]) + PS'(p_ff[10]);
      sum[8] = PS'(p_ff[11]);
      for (int i = 0; i < 9; i++) begin
         rot_in[i] = RW'((sum[i] + $signed(PS'(HALF))) >>> F);
      end
      // The y row of the x rotation enters unrounded and negated.
      rot_in[5] = -RW'(sx2_ff);
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         mp_in[i] = MW'(rot_ff[i]) * MW'($signed(scale[i % 3]));
         qv[i] = QW'((mp_ff[i] + $signed(MW'(HALF))) >>> F);
         if (qv[i] > SAT_MAX) m_in[i] = 32'h7fffffff;
         else if (qv[i] < SAT_MIN) m_in[i] = 32'h80000000;
         else m_in[i] = qv[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sx_ff <= sin_x;
         cx_ff <= cos_x;
         sy_ff <= sin_y;
         cy_ff <= cos_y;
         sz_ff <= sin_z;
         cz_ff <= cos_z;
         t_ff <= t_in;
         u_ff <= u_in;
      end
      if (en[1]) begin
         p_ff <= p_in;
         sx2_ff <= sx_ff;
      end
      if (en[2]) begin
         rot_ff <= rot_in;
      end
      if (en[3]) begin
         mp_ff <= mp_in;
      end
      if (en[4]) begin
         m_ff <= m_in;
      end
   end

   assign m = m_ff;

endmodule

// ===== hdl/euler_trs_model_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_trs_model_matrix: TRS model matrix from Euler angles
// Builds the twelve upper entries of a 4x4 model matrix, rotation Ry*Rx*Rz.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction on the req_ channel carries three angles in degrees (Q10.6),
//   a position and a per-axis scale (Q16.16). For each one, the rsp_ channel
//   delivers one matrix: m00..m22 are the rotation entries times the column
//   scale, rounded and saturated, and m03, m13, m23 are the position.
//   Six sine/cosine lanes run side by side (8 stages each), then a 5-stage
//   merge pipeline forms and scales the rotation, 13 register stages in all.
//   Throughput is one transaction per cycle while rsp_ready stays high, set by
//   the fully pipelined lanes and merge multipliers.
//   Every stage holds its transaction while the stage after it is full and
//   stalled, so a stalled receiver fills the pipeline before req_ready drops;
//   bubbles are squeezed out. Reset empties the pipeline; the
//   sine table is constant logic and needs no initialization.
// ----------------------------------------------------------------------------
module euler_trs_model_matrix #(
   parameter int SINE_TABLE_DEPTH = 256,
   parameter int FRAC_BITS        = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   input  logic signed [15:0] req_angle_z,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_scale_x,
   input  logic signed [31:0] req_scale_y,
   input  logic signed [31:0] req_scale_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_m00,
   output logic signed [31:0] rsp_m01,
   output logic signed [31:0] rsp_m02,
   output logic signed [31:0] rsp_m03,
   output logic signed [31:0] rsp_m10,
   output logic signed [31:0] rsp_m11,
   output logic signed [31:0] rsp_m12,
   output logic signed [31:0] rsp_m13,
   output logic signed [31:0] rsp_m20,
   output logic signed [31:0] rsp_m21,
   output logic signed [31:0] rsp_m22,
   output logic signed [31:0] rsp_m23
);
   import etm_pkg::*;

   localparam int SW = FRAC_BITS + 2;
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0]   adv;
   side_type              side_ff [NUM_STAGES];
   side_type              side_in;

   logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;
   logic [8:0][31:0]     m;

   // A stage may load when it is empty or its contents move on.
   assign adv[NUM_STAGES] = rsp_ready;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign side_in = {req_pos_z, req_pos_y, req_pos_x,
                     req_scale_z, req_scale_y, req_scale_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) side_ff[0] <= side_in;
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (adv[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   etm_sine_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS),
                   .COSINE(1'b0)) u_sin_x (
      .clock(clock), .en(adv[LANE_STAGES-1:0]), .angle(req_angle_x), .value(sx));
   etm_sine_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS),
                   .COSINE(1'b1)) u_cos_x (
      .clock(clock), .en(adv[LANE_STAGES-1:0]), .angle(req_angle_x), .value(cx));
   etm_sine_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS),
                   .COSINE(1'b0)) u_sin_y (
      .clock(clock), .en(adv[LANE_STAGES-1:0]), .angle(req_angle_y), .value(sy));
   etm_sine_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS),
                   .COSINE(1'b1)) u_cos_y (
      .clock(clock), .en(adv[LANE_STAGES-1:0]), .angle(req_angle_y), .value(cy));
   etm_sine_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS),
                   .COSINE(1'b0)) u_sin_z (
      .clock(clock), .en(adv[LANE_STAGES-1:0]), .angle(req_angle_z), .value(sz));
   etm_sine_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .FRAC_BITS(FRAC_BITS),
                   .COSINE(1'b1)) u_cos_z (
      .clock(clock), .en(adv[LANE_STAGES-1:0]), .angle(req_angle_z), .value(cz));

   // The scale is picked up from the stage whose item enters the scaling multiply.
   etm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock(clock),
      .en(adv[NUM_STAGES-1:LANE_STAGES]),
      .sin_x(sx), .cos_x(cx), .sin_y(sy), .cos_y(cy), .sin_z(sz), .cos_z(cz),
      .scale(side_ff[NUM_STAGES-3].scale),
      .m(m)
   );

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   assign rsp_m00 = $signed(m[0]);
   assign rsp_m01 = $signed(m[1]);
   assign rsp_m02 = $signed(m[2]);
   assign rsp_m10 = $signed(m[3]);
   assign rsp_m11 = $signed(m[4]);
   assign rsp_m12 = $signed(m[5]);
   assign rsp_m20 = $signed(m[6]);
   assign rsp_m21 = $signed(m[7]);
   assign rsp_m22 = $signed(m[8]);
   assign rsp_m03 = $signed(side_ff[NUM_STAGES-1].pos[0]);
   assign rsp_m13 = $signed(side_ff[NUM_STAGES-1].pos[1]);
   assign rsp_m23 = $signed(side_ff[NUM_STAGES-1].pos[2]);

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted transaction did not enter the first stage");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while the output drains");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LANE_STAGES-1] |-> (sx <= ONE) && (sx >= -ONE) && (cz <= ONE) && (cz >= -ONE))
      else $error("lane result outside the unit range");

endmodule
